// File: sv/lru_pkg.sv
package lru_pkg;

  // Number of key-value entries held in the store.
  localparam int MAX_ENTRIES = 16;

  // Widths of entry indexes, recency ranks and the occupancy count.
  localparam int IDX_W  = $clog2(MAX_ENTRIES);
  localparam int RANK_W = $clog2(MAX_ENTRIES);
  localparam int OCC_W  = $clog2(MAX_ENTRIES + 1);

  // Capacity register width and the width used to compare it with occupancy.
  localparam int CAP_W = 5;
  localparam int CMP_W = (CAP_W > OCC_W) ? CAP_W : OCC_W;

  // Capacity register value after reset.
  localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

  // Operation codes carried on func.
  localparam logic FUNC_GET = 1'b0;
  localparam logic FUNC_PUT = 1'b1;

  typedef logic signed [31:0]   key_t;
  typedef logic signed [31:0]   value_t;
  typedef logic [RANK_W-1:0]    rank_t;
  typedef logic [MAX_ENTRIES-1:0] entry_mask_t;

endpackage

// File: sv/lru_key_value_cache_core.sv
// Fully associative key-value cache with least-recently-used replacement.
// Raise start for one cycle with func (get or put), lookup_key and
// write_value; busy never rises, so a new beat may be sent every cycle.
// The beat is registered, all entries are compared and updated in the
// following cycle, and the result is registered and shown for exactly
// one cycle with done high. The receiver cannot stall it, so it
// must take found and read_value whenever done is high. read_value is zero
// on a get miss and on every put. The throughput of one beat per cycle is
// set by the combinational parallel key compare and rank update over all
// entries. capacity_limit may be written only while no beat is in flight;
// zero acts as one and values above the entry count act as the entry count.
module lru_key_value_cache_core
  import lru_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  output logic             busy,
  input  logic             func,
  input  key_t             lookup_key,
  input  value_t           write_value,
  input  logic             capacity_limit_valid,
  output logic             capacity_limit_ready,
  input  logic [CAP_W-1:0] capacity_limit,
  output logic             done,
  output logic             found,
  output value_t           read_value
);

  // Request register.
  logic   req_valid;
  logic   req_func;
  key_t   req_key;
  value_t req_value;

  // Entry storage and bookkeeping.
  entry_mask_t       entry_valid;
  key_t              entry_key   [MAX_ENTRIES];
  value_t            entry_value [MAX_ENTRIES];
  rank_t             recency_rank[MAX_ENTRIES];
  logic [OCC_W-1:0]  occupancy;
  logic [CAP_W-1:0]  cap_limit;

  // Next-state values.
  entry_mask_t       entry_valid_next;
  rank_t             rank_next[MAX_ENTRIES];
  logic [OCC_W-1:0]  occupancy_next;

  // Lookup and replacement signals.
  entry_mask_t       match;
  entry_mask_t       victim;
  entry_mask_t       kept;
  entry_mask_t       free_onehot;
  logic              hit;
  value_t            hit_value;
  rank_t             hit_rank;
  rank_t             oldest_rank;
  logic [CMP_W-1:0]  cap_ext;
  logic [CMP_W-1:0]  eff_cap;
  logic              evict_needed;
  logic              put_miss;

  // The block never stalls and takes configuration at any time.
  assign busy                 = 1'b0;
  assign capacity_limit_ready = 1'b1;

  // Capacity register.
  always_ff @(posedge clk) begin
    if (rst) begin
      cap_limit <= CAP_RESET;
    end else if (capacity_limit_valid && capacity_limit_ready) begin
      cap_limit <= capacity_limit;
    end
  end

  // Register each accepted beat.
  always_ff @(posedge clk) begin
    if (rst) begin
      req_valid <= 1'b0;
    end else begin
      req_valid <= start && !busy;
    end
  end

  always_ff @(posedge clk) begin
    if (start && !busy) begin
      req_func  <= func;
      req_key   <= lookup_key;
      req_value <= write_value;
    end
  end

  // Parallel key compare and selection of the hit entry's value and rank.
  always_comb begin
    hit_value = '0;
    hit_rank  = '0;
    for (int i = 0; i < MAX_ENTRIES; i++) begin
      match[i] = entry_valid[i] && (entry_key[i] == req_key);
      if (match[i]) begin
        hit_value = hit_value | entry_value[i];
        hit_rank  = hit_rank | recency_rank[i];
      end
    end
  end

  assign hit = |match;

  // Effective capacity: zero behaves as one, large values saturate.
  assign cap_ext = CMP_W'(cap_limit);

  always_comb begin
    if (cap_ext == '0) begin
      eff_cap = CMP_W'(1);
    end else if (cap_ext > CMP_W'(MAX_ENTRIES)) begin
      eff_cap = CMP_W'(MAX_ENTRIES);
    end else begin
      eff_cap = cap_ext;
    end
  end

  assign put_miss     = req_valid && (req_func == FUNC_PUT) && !hit;
  assign evict_needed = CMP_W'(occupancy) >= eff_cap;

  // The least recent valid entry holds rank occupancy - 1.
  assign oldest_rank = RANK_W'(occupancy - OCC_W'(1));

  always_comb begin
    for (int i = 0; i < MAX_ENTRIES; i++) begin
      victim[i] = evict_needed && entry_valid[i] && (recency_rank[i] == oldest_rank);
    end
  end

  // Lowest free entry after any eviction, found as the lowest zero bit.
  assign kept        = entry_valid & ~victim;
  assign free_onehot = ~kept & (kept + entry_mask_t'(1));

  // Rank and valid updates for touch and insert.
  always_comb begin
    entry_valid_next = entry_valid;
    occupancy_next   = occupancy;
    for (int i = 0; i < MAX_ENTRIES; i++) begin
      rank_next[i] = recency_rank[i];
    end
    if (req_valid && hit) begin
      for (int i = 0; i < MAX_ENTRIES; i++) begin
        if (match[i]) begin
          rank_next[i] = '0;
        end else if (entry_valid[i] && (recency_rank[i] < hit_rank)) begin
          rank_next[i] = recency_rank[i] + rank_t'(1);
        end
      end
    end else if (put_miss) begin
      entry_valid_next = kept | free_onehot;
      if (!evict_needed) begin
        occupancy_next = occupancy + OCC_W'(1);
      end
      for (int i = 0; i < MAX_ENTRIES; i++) begin
        if (free_onehot[i]) begin
          rank_next[i] = '0;
        end else if (kept[i]) begin
          rank_next[i] = recency_rank[i] + rank_t'(1);
        end
      end
    end
  end

  // Control state of the entries.
  always_ff @(posedge clk) begin
    if (rst) begin
      entry_valid <= '0;
      occupancy   <= '0;
    end else begin
      entry_valid <= entry_valid_next;
      occupancy   <= occupancy_next;
    end
  end

  // Entry payload: keys, values and ranks.
  always_ff @(posedge clk) begin
    for (int i = 0; i < MAX_ENTRIES; i++) begin
      recency_rank[i] <= rank_next[i];
      if (req_valid && (req_func == FUNC_PUT) && match[i]) begin
        entry_value[i] <= req_value;
      end
      if (put_miss && free_onehot[i]) begin
        entry_key[i]   <= req_key;
        entry_value[i] <= req_value;
      end
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= req_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (req_valid) begin
      found      <= hit;
      read_value <= (req_func == FUNC_GET && hit) ? hit_value : '0;
    end
  end

  // A registered beat always produces a result in the next cycle.
  assert property (@(posedge clk) disable iff (rst) req_valid |=> done)
    else $error("registered beat did not produce a result");

  // Valid keys are distinct, so at most one entry can match.
  assert property (@(posedge clk) disable iff (rst) $onehot0(match))
    else $error("more than one entry matched the key");

  // The occupancy count tracks the number of valid entries.
  assert property (@(posedge clk) disable iff (rst)
    $countones(entry_valid) == int'(occupancy))
    else $error("occupancy does not match the valid entries");

  // A put that misses always finds a free entry.
  assert property (@(posedge clk) disable iff (rst) put_miss |-> $onehot(free_onehot))
    else $error("put miss found no free entry");

  // Eviction removes exactly one entry.
  assert property (@(posedge clk) disable iff (rst)
    (put_miss && evict_needed) |-> $onehot(victim))
    else $error("eviction did not select exactly one victim");

endmodule
